>>> sv/sac_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the speed alarm controller.
// No dependencies.
package sac_pkg;

	typedef enum logic [3:0] {
		ST_IDLE       = 4'd0,
		ST_LOW_BEEP   = 4'd1,
		ST_LOW_WAIT   = 4'd2,
		ST_MID_BEEP1  = 4'd3,
		ST_MID_WAIT1  = 4'd4,
		ST_MID_BEEP2  = 4'd5,
		ST_MID_WAIT2  = 4'd6,
		ST_MID_HOLD   = 4'd7,
		ST_HIGH_BEEP  = 4'd8,
		ST_HIGH_WAIT  = 4'd9,
		ST_HIGH_CHECK = 4'd10
	} alarm_state_t;

	typedef enum logic [2:0] {
		CFG_LOW_THR     = 3'd0,
		CFG_MID_THR     = 3'd1,
		CFG_HIGH_THR    = 3'd2,
		CFG_SHORT_BEEP  = 3'd3,
		CFG_LONG_BEEP   = 3'd4,
		CFG_RED_LONG    = 3'd5,
		CFG_RED_SHORT   = 3'd6
	} cfg_index_t;

	localparam int SPEED_W = 10;
	localparam int TICK_W  = 8;
	localparam int CFG_W   = 10;

	localparam logic REQ_TICK  = 1'b0;
	localparam logic REQ_SPEED = 1'b1;

	localparam logic [SPEED_W-1:0] LOW_THR_RST    = 10'd55;
	localparam logic [SPEED_W-1:0] MID_THR_RST    = 10'd75;
	localparam logic [SPEED_W-1:0] HIGH_THR_RST   = 10'd115;
	localparam logic [TICK_W-1:0]  SHORT_BEEP_RST = 8'd50;
	localparam logic [TICK_W-1:0]  LONG_BEEP_RST  = 8'd100;
	localparam logic [TICK_W-1:0]  RED_LONG_RST   = 8'd200;
	localparam logic [TICK_W-1:0]  RED_SHORT_RST  = 8'd50;

endpackage

>>> sv/speed_alarm_controller_unit.sv
`timescale 1ns / 1ps
// Speed alarm controller: input register, state update, result register.
// Throughput: one item per cycle unless a held result waits on out_ready.
// The state update is a single compare-and-load step.
// Reset: idle state, hold counters zero, configuration registers at defaults.
// Depends on sac_pkg.
module speed_alarm_controller_unit
	import sac_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [CFG_W-1:0]   cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               req_type,
	input  logic [SPEED_W-1:0] speed,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               buzzer_on,
	output logic               red_led_on,
	output logic [3:0]         alarm_state
);

	logic [SPEED_W-1:0] low_thr_q, mid_thr_q, high_thr_q;
	logic [TICK_W-1:0]  short_beep_q, long_beep_q, red_long_q, red_short_q;

	logic               valid_s1;
	logic               req_type_s1;
	logic [SPEED_W-1:0] speed_s1;

	alarm_state_t       state_q, state_d;
	logic [TICK_W-1:0]  buzzer_q, buzzer_d;
	logic [TICK_W-1:0]  red_q, red_d;

	logic               out_valid_q;
	logic               buzzer_on_q, red_on_q;
	logic [3:0]         alarm_state_q;

	logic               advance;

	assign advance   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign out_valid = out_valid_q;
	assign buzzer_on = buzzer_on_q;
	assign red_led_on  = red_on_q;
	assign alarm_state = alarm_state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_thr_q    <= LOW_THR_RST;
			mid_thr_q    <= MID_THR_RST;
			high_thr_q   <= HIGH_THR_RST;
			short_beep_q <= SHORT_BEEP_RST;
			long_beep_q  <= LONG_BEEP_RST;
			red_long_q   <= RED_LONG_RST;
			red_short_q  <= RED_SHORT_RST;
		end else if (cfg_we) begin
			case (cfg_index_t'(cfg_index))
				CFG_LOW_THR:    low_thr_q    <= cfg_data;
				CFG_MID_THR:    mid_thr_q    <= cfg_data;
				CFG_HIGH_THR:   high_thr_q   <= cfg_data;
				CFG_SHORT_BEEP: short_beep_q <= cfg_data[TICK_W-1:0];
				CFG_LONG_BEEP:  long_beep_q  <= cfg_data[TICK_W-1:0];
				CFG_RED_LONG:   red_long_q   <= cfg_data[TICK_W-1:0];
				CFG_RED_SHORT:  red_short_q  <= cfg_data[TICK_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			req_type_s1 <= req_type;
			speed_s1    <= speed;
		end
	end

	always_comb begin
		state_d  = state_q;
		buzzer_d = buzzer_q;
		red_d    = red_q;
		if (req_type_s1 == REQ_TICK) begin
			if (buzzer_q != '0) buzzer_d = buzzer_q - 1'b1;
			if (red_q != '0)    red_d    = red_q - 1'b1;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (speed_s1 > low_thr_q) state_d = ST_LOW_BEEP;
				end
				ST_LOW_BEEP: begin
					buzzer_d = short_beep_q;
					state_d  = ST_LOW_WAIT;
				end
				ST_LOW_WAIT: begin
					if (speed_s1 < low_thr_q)       state_d = ST_IDLE;
					else if (speed_s1 > mid_thr_q)  state_d = ST_MID_BEEP1;
				end
				ST_MID_BEEP1: begin
					buzzer_d = long_beep_q;
					red_d    = red_long_q;
					state_d  = ST_MID_WAIT1;
				end
				ST_MID_WAIT1: begin
					if (buzzer_q == '0) state_d = ST_MID_BEEP2;
				end
				ST_MID_BEEP2: begin
					buzzer_d = long_beep_q;
					red_d    = red_long_q;
					state_d  = ST_MID_WAIT2;
				end
				ST_MID_WAIT2: begin
					if (buzzer_q == '0) state_d = ST_MID_HOLD;
				end
				ST_MID_HOLD: begin
					red_d = red_long_q;
					if (speed_s1 < mid_thr_q)       state_d = ST_LOW_WAIT;
					else if (speed_s1 > high_thr_q) state_d = ST_HIGH_BEEP;
				end
				ST_HIGH_BEEP: begin
					buzzer_d = short_beep_q;
					red_d    = red_short_q;
					state_d  = ST_HIGH_WAIT;
				end
				ST_HIGH_WAIT: begin
					if (buzzer_q == '0) state_d = ST_HIGH_CHECK;
				end
				ST_HIGH_CHECK: begin
					if (speed_s1 < high_thr_q) state_d = ST_MID_HOLD;
					else                       state_d = ST_HIGH_BEEP;
				end
				default: state_d = ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			buzzer_q <= '0;
			red_q    <= '0;
		end else if (advance) begin
			state_q  <= state_d;
			buzzer_q <= buzzer_d;
			red_q    <= red_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			buzzer_on_q   <= (buzzer_d != '0);
			red_on_q      <= (red_d != '0);
			alarm_state_q <= state_d;
		end
	end

	a_state_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (alarm_state_q <= ST_HIGH_CHECK))
		else $error("alarm state code out of range");

	a_tick_keeps_state: assert property (@(posedge clk) disable iff (!arst_n)
		advance && (req_type_s1 == REQ_TICK) |=> state_q == $past(state_q))
		else $error("state changed on a tick");

	a_tick_counts_down: assert property (@(posedge clk) disable iff (!arst_n)
		advance && (req_type_s1 == REQ_TICK) && (buzzer_q != '0)
		|=> buzzer_q == $past(buzzer_q) - 1'b1)
		else $error("buzzer counter did not decrement on tick");

	a_result_matches: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> (buzzer_on_q == (buzzer_q != '0)) && (red_on_q == (red_q != '0))
		&& (alarm_state_q == state_q))
		else $error("result register out of step with state");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> in_ready)
		else $error("input stalled with empty result register");

endmodule

>>> tb/sv/speed_alarm_controller_unit_test.sv
`timescale 1ns / 1ps
// Self-checking bench for speed_alarm_controller_unit: queued tick and speed readings,
// random stalls on both channels, predicted alarm outputs checked per transfer.
// Depends on sac_pkg and speed_alarm_controller_unit.
module speed_alarm_controller_unit_test;
	import sac_pkg::*;

	localparam logic [2:0] CFG_SPARE_IDX = 3'd7;

	typedef struct packed {
		logic               kind;
		logic [SPEED_W-1:0] spd;
	} reading_t;

	typedef struct packed {
		logic       buzz;
		logic       red;
		logic [3:0] st;
	} alarm_out_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic [2:0]         cfg_index = '0;
	logic [CFG_W-1:0]   cfg_data = '0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic               req_type = REQ_TICK;
	logic [SPEED_W-1:0] speed = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic               buzzer_on;
	logic               red_led_on;
	logic [3:0]         alarm_state;

	speed_alarm_controller_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.req_type(req_type),
		.speed(speed),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.buzzer_on(buzzer_on),
		.red_led_on(red_led_on),
		.alarm_state(alarm_state)
	);

	// alarm model state and its copy of the registers
	alarm_state_t       model_state = ST_IDLE;
	logic [TICK_W-1:0]  buzz_left = '0;
	logic [TICK_W-1:0]  red_left = '0;
	logic [SPEED_W-1:0] thr_low = LOW_THR_RST;
	logic [SPEED_W-1:0] thr_mid = MID_THR_RST;
	logic [SPEED_W-1:0] thr_high = HIGH_THR_RST;
	logic [TICK_W-1:0]  beep_short = SHORT_BEEP_RST;
	logic [TICK_W-1:0]  beep_long = LONG_BEEP_RST;
	logic [TICK_W-1:0]  red_long = RED_LONG_RST;
	logic [TICK_W-1:0]  red_short = RED_SHORT_RST;

	reading_t   pending_inputs[$];
	alarm_out_t predicted_alarms[$];
	int         mismatches = 0;
	logic       in_sent = 1'b0;
	int         in_wait = 0;
	int         in_calm = 0;
	int         out_stall = 0;
	int         out_calm = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic int pick_gap(inout int calm);
		int r;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3) begin
			calm = $urandom_range(20, 80);
			return 0;
		end
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic alarm_out_t advance_alarm(logic kind, logic [SPEED_W-1:0] spd);
		alarm_out_t r;
		if (kind == REQ_TICK) begin
			if (buzz_left != 0)
				buzz_left--;
			if (red_left != 0)
				red_left--;
		end else begin
			case (model_state)
				ST_IDLE: begin
					if (spd > thr_low)
						model_state = ST_LOW_BEEP;
				end
				ST_LOW_BEEP: begin
					buzz_left = beep_short;
					model_state = ST_LOW_WAIT;
				end
				ST_LOW_WAIT: begin
					if (spd < thr_low)
						model_state = ST_IDLE;
					else if (spd > thr_mid)
						model_state = ST_MID_BEEP1;
				end
				ST_MID_BEEP1, ST_MID_BEEP2: begin
					buzz_left = beep_long;
					red_left = red_long;
					model_state = (model_state == ST_MID_BEEP1) ? ST_MID_WAIT1 : ST_MID_WAIT2;
				end
				ST_MID_WAIT1: begin
					if (buzz_left == 0)
						model_state = ST_MID_BEEP2;
				end
				ST_MID_WAIT2: begin
					if (buzz_left == 0)
						model_state = ST_MID_HOLD;
				end
				ST_HIGH_WAIT: begin
					if (buzz_left == 0)
						model_state = ST_HIGH_CHECK;
				end
				ST_MID_HOLD: begin
					red_left = red_long;
					if (spd < thr_mid)
						model_state = ST_LOW_WAIT;
					else if (spd > thr_high)
						model_state = ST_HIGH_BEEP;
				end
				ST_HIGH_BEEP: begin
					buzz_left = beep_short;
					red_left = red_short;
					model_state = ST_HIGH_WAIT;
				end
				ST_HIGH_CHECK: begin
					model_state = (spd < thr_high) ? ST_MID_HOLD : ST_HIGH_BEEP;
				end
				default: begin
					model_state = ST_IDLE;
				end
			endcase
		end
		r.buzz = (buzz_left != 0);
		r.red = (red_left != 0);
		r.st = model_state;
		return r;
	endfunction

	// driver: hold each reading until its transfer, then advance
	always @(negedge clk) begin
		reading_t item;
		if (arst_n && (!in_valid || in_sent)) begin
			if (in_wait > 0) begin
				in_valid <= 1'b0;
				in_wait--;
			end else if (pending_inputs.size() != 0) begin
				item = pending_inputs.pop_front();
				in_valid <= 1'b1;
				req_type <= item.kind;
				speed <= item.spd;
				in_wait = pick_gap(in_calm);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (out_stall > 0) begin
			out_ready <= 1'b0;
			out_stall--;
		end else begin
			out_ready <= 1'b1;
			if ($urandom_range(0, 99) < 20)
				out_stall = pick_gap(out_calm);
		end
	end

	// monitor: track register writes, predict on input transfers, check output transfers
	always @(posedge clk) begin
		alarm_out_t want;
		in_sent <= in_valid && in_ready;
		if (arst_n) begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_LOW_THR:    thr_low = cfg_data[SPEED_W-1:0];
					CFG_MID_THR:    thr_mid = cfg_data[SPEED_W-1:0];
					CFG_HIGH_THR:   thr_high = cfg_data[SPEED_W-1:0];
					CFG_SHORT_BEEP: beep_short = cfg_data[TICK_W-1:0];
					CFG_LONG_BEEP:  beep_long = cfg_data[TICK_W-1:0];
					CFG_RED_LONG:   red_long = cfg_data[TICK_W-1:0];
					CFG_RED_SHORT:  red_short = cfg_data[TICK_W-1:0];
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (predicted_alarms.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result: buzzer=%0b red=%0b state=%0d",
							buzzer_on, red_led_on, alarm_state);
				end else begin
					want = predicted_alarms.pop_front();
					if (buzzer_on !== want.buzz || red_led_on !== want.red ||
						alarm_state !== want.st) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected %0b %0b %0d, got %0b %0b %0d",
								want.buzz, want.red, want.st,
								buzzer_on, red_led_on, alarm_state);
					end
				end
			end
			if (in_valid && in_ready)
				predicted_alarms.push_back(advance_alarm(req_type, speed));
		end
	end

	task automatic push_reading(logic kind, logic [SPEED_W-1:0] spd);
		reading_t item;
		item.kind = kind;
		item.spd = spd;
		pending_inputs.push_back(item);
	endtask

	task automatic push_speed(int spd);
		push_reading(REQ_SPEED, spd[SPEED_W-1:0]);
	endtask

	task automatic push_ticks(int n);
		logic [SPEED_W-1:0] junk;
		repeat (n) begin
			junk = SPEED_W'($urandom);
			push_reading(REQ_TICK, junk);
		end
	endtask

	task automatic drain();
		while (pending_inputs.size() != 0 || in_valid || predicted_alarms.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic set_reg(logic [2:0] idx, logic [CFG_W-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
	endtask

	task automatic configure(logic [SPEED_W-1:0] lo, logic [SPEED_W-1:0] mid,
			logic [SPEED_W-1:0] hi, logic [TICK_W-1:0] sb, logic [TICK_W-1:0] lb,
			logic [TICK_W-1:0] rl, logic [TICK_W-1:0] rs);
		logic [1:0] pad;
		set_reg(CFG_LOW_THR, lo);
		set_reg(CFG_MID_THR, mid);
		set_reg(CFG_HIGH_THR, hi);
		pad = 2'($urandom);
		set_reg(CFG_SHORT_BEEP, {pad, sb});
		pad = 2'($urandom);
		set_reg(CFG_LONG_BEEP, {pad, lb});
		pad = 2'($urandom);
		set_reg(CFG_RED_LONG, {pad, rl});
		pad = 2'($urandom);
		set_reg(CFG_RED_SHORT, {pad, rs});
		if ($urandom_range(0, 1))
			set_reg(CFG_SPARE_IDX, CFG_W'($urandom));
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// mostly speed runs parked near a threshold with tick bursts to drain the holds
	task automatic run_random(int n);
		int made;
		int target;
		int delta;
		int hold_max;
		int burst;
		int runs;
		made = 0;
		hold_max = beep_short;
		if (beep_long > hold_max)
			hold_max = beep_long;
		if (red_long > hold_max)
			hold_max = red_long;
		if (red_short > hold_max)
			hold_max = red_short;
		while (made < n) begin
			if ($urandom_range(0, 99) < 15) begin
				repeat ($urandom_range(1, 4)) begin
					push_reading(1'($urandom_range(0, 1)), SPEED_W'($urandom));
					made++;
				end
			end else begin
				case ($urandom_range(0, 2))
					0: target = thr_low;
					1: target = thr_mid;
					default: target = thr_high;
				endcase
				delta = $urandom_range(0, 3);
				target = target + delta - 1;
				if (target < 0)
					target = 0;
				if (target > 1023)
					target = 1023;
				runs = $urandom_range(2, 8);
				for (int k = 0; k < runs && made < n; k++) begin
					push_speed(target);
					made++;
					if ($urandom_range(0, 99) < 45) begin
						burst = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 3) : hold_max + 1;
						push_ticks(burst);
						made += burst;
					end
				end
			end
		end
	endtask

	function automatic logic [TICK_W-1:0] few_ticks();
		return TICK_W'($urandom_range(0, 5));
	endfunction

	initial begin
		logic [SPEED_W-1:0] lo;
		logic [SPEED_W-1:0] mid;
		logic [SPEED_W-1:0] hi;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset values: tick ignores speed, equal speed holds idle
		push_reading(REQ_TICK, 10'd1023);
		push_speed(55);
		push_speed(56);
		push_speed(0);
		push_speed(55);
		push_speed(76);
		push_speed(0);
		drain();

		// short holds: climb to the top band, retrigger, then step back down
		configure(10, 20, 30, 1, 2, 3, 1);
		set_reg(CFG_SPARE_IDX, 10'h3ff);
		@(negedge clk);
		cfg_we <= 1'b0;
		push_speed(31);
		push_speed(31);
		push_speed(31);
		push_speed(31);
		push_ticks(2);
		push_speed(31);
		push_speed(31);
		push_ticks(2);
		push_speed(31);
		push_speed(31);
		push_speed(31);
		push_ticks(1);
		push_speed(31);
		push_speed(30);
		push_speed(31);
		push_ticks(1);
		push_speed(31);
		push_speed(29);
		push_speed(20);
		push_speed(19);
		push_speed(9);
		drain();

		for (int phase = 0; phase < 9; phase++) begin
			lo = SPEED_W'($urandom_range(0, 1000));
			mid = lo + SPEED_W'($urandom_range(0, 8));
			hi = mid + SPEED_W'($urandom_range(0, 8));
			case (phase)
				1: configure(lo, mid, hi, 0, 0, 0, 0);
				2: configure(0, 0, 0, few_ticks(), few_ticks(), few_ticks(), few_ticks());
				3: configure(1023, 1023, 1023, few_ticks(), few_ticks(), few_ticks(),
					few_ticks());
				4: configure(lo, mid, hi, 255, 255, 255, 255);
				5: configure(SPEED_W'($urandom), SPEED_W'($urandom), SPEED_W'($urandom),
					TICK_W'($urandom), TICK_W'($urandom), TICK_W'($urandom),
					TICK_W'($urandom));
				default: configure(lo, mid, hi, few_ticks(), few_ticks(), few_ticks(),
					few_ticks());
			endcase
			run_random(110);
			drain();
		end

		repeat (10) @(posedge clk);
		if (mismatches == 0 && predicted_alarms.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
